FILE: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

	typedef logic signed [31:0] word_t;

	typedef enum logic [2:0] {
		FN_APPEND    = 3'd0,
		FN_DEL_FIRST = 3'd1,
		FN_DEL_POS   = 3'd2,
		FN_DEL_LAST  = 3'd3,
		FN_TRAVERSE  = 3'd4
	} func_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_e;

	// per-cell control: load this cycle, and whether from the right neighbor
	typedef struct packed {
		logic load;
		logic from_next;
	} cell_ctrl_t;

endpackage

FILE: src/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels for requests and results of the deque unit.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	import bdq_pkg::*;

	logic        valid;
	logic        ready;
	logic [2:0]  func;
	word_t       value;
	logic [4:0]  position;

	modport source(output valid, func, value, position, input ready);
	modport sink(input valid, func, value, position, output ready);
endinterface

interface bdq_rsp_if;
	import bdq_pkg::*;

	logic        valid;
	logic        ready;
	word_t       value_res;
	logic [1:0]  status;
	logic        last;

	modport source(output valid, value_res, status, last, input ready);
	modport sink(input valid, value_res, status, last, output ready);
endinterface

FILE: src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque chain; loads from its right neighbor or from
// the shared input word.
// ----------------------------------------------------------------------------
module bdq_cell (
	input  logic               clk,
	input  bdq_pkg::cell_ctrl_t ctrl,
	input  bdq_pkg::word_t     next_word,
	input  bdq_pkg::word_t     in_word,
	output bdq_pkg::word_t     data
);
	import bdq_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= ctrl.from_next ? next_word : in_word;
		end
	end

	assign data = data_q;

endmodule

FILE: src/bounded_deque_with_positional_delete_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_delete_unit
// Ordered store of up to DEPTH signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// Append, remove first, remove at a 1-based position and remove last each give
// one status transfer. Removal shifts every cell at or above the removed slot
// one place toward the head. Traverse gives one transfer per stored word, one
// per cycle while the sink keeps up: the chain rotates the first count cells
// by one slot per word, reading the head cell, and is back in its original
// order at the end. A request is taken only when no traverse is in progress
// and the result register is free or being drained. Func codes 5 to 7 are
// dropped silently. Entries hold no reset value; only slots below count are
// ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_delete_unit #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);
	import bdq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = 5;
	localparam int MW = (CW > PW) ? CW : PW;

	typedef enum logic {S_IDLE, S_TRAV} state_e;

	state_e            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     trav_q;
	logic              out_valid_q;
	word_t             value_res_q;
	status_e           status_q;
	logic              last_q;

	word_t             cell_data [DEPTH];
	word_t             in_word;

	logic              slot_free;
	logic              accept;
	logic              trav_step;
	logic              trav_last;
	logic              is_full;
	logic              is_empty;
	logic              pos_bad;
	logic [CW-1:0]     cnt_m1;
	logic [MW-1:0]     pos_m1;

	logic              do_app;
	logic              do_shift;
	logic [IW-1:0]     shift_from;
	logic              do_dec;
	logic              res_load;
	status_e           res_status;
	logic              start_trav;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign trav_step = (state_q == S_TRAV) && slot_free;

	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign cnt_m1    = count_q - CW'(1);
	assign trav_last = (CW'(trav_q) == cnt_m1);
	assign pos_bad   = (req.position == '0) || (MW'(req.position) > MW'(count_q));
	assign pos_m1    = MW'(req.position) - MW'(1);

	always_comb begin
		do_app     = 1'b0;
		do_shift   = 1'b0;
		shift_from = '0;
		do_dec     = 1'b0;
		res_load   = 1'b0;
		res_status = ST_OK;
		start_trav = 1'b0;
		if (accept) begin
			case (req.func)
				FN_APPEND: begin
					res_load = 1'b1;
					if (is_full) begin
						res_status = ST_FULL;
					end else begin
						do_app = 1'b1;
					end
				end
				FN_DEL_FIRST: begin
					res_load = 1'b1;
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						do_shift = 1'b1;
						do_dec   = 1'b1;
					end
				end
				FN_DEL_POS: begin
					res_load = 1'b1;
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else if (pos_bad) begin
						res_status = ST_RANGE;
					end else begin
						do_shift   = 1'b1;
						shift_from = pos_m1[IW-1:0];
						do_dec     = 1'b1;
					end
				end
				FN_DEL_LAST: begin
					res_load = 1'b1;
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						do_dec = 1'b1;
					end
				end
				FN_TRAVERSE: begin
					if (is_empty) begin
						res_load   = 1'b1;
						res_status = ST_EMPTY;
					end else begin
						start_trav = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// during traverse the head word wraps around to the tail slot
	assign in_word = trav_step ? cell_data[0] : req.value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		word_t      next_word;

		assign ctrl.load = (do_app && (count_q == CW'(i)))
			|| (do_shift && (IW'(i) >= shift_from))
			|| trav_step;
		assign ctrl.from_next = do_shift || (trav_step && (CW'(i) != cnt_m1));

		if (i == DEPTH - 1) begin : g_tail
			assign next_word = cell_data[i];
		end else begin : g_body
			assign next_word = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.next_word (next_word),
			.in_word   (in_word),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			trav_q      <= '0;
			out_valid_q <= 1'b0;
			value_res_q <= '0;
			status_q    <= ST_OK;
			last_q      <= 1'b0;
		end else begin
			if (do_app) begin
				count_q <= count_q + CW'(1);
			end else if (do_dec) begin
				count_q <= cnt_m1;
			end

			case (state_q)
				S_IDLE: begin
					if (start_trav) begin
						state_q <= S_TRAV;
						trav_q  <= '0;
					end
				end
				S_TRAV: begin
					if (trav_step) begin
						if (trav_last) begin
							state_q <= S_IDLE;
						end else begin
							trav_q <= trav_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (res_load) begin
				out_valid_q <= 1'b1;
				value_res_q <= '0;
				status_q    <= res_status;
				last_q      <= 1'b1;
			end else if (trav_step) begin
				out_valid_q <= 1'b1;
				value_res_q <= cell_data[0];
				status_q    <= ST_OK;
				last_q      <= trav_last;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_res = value_res_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

endmodule

FILE: src/bdq_chk.sv
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks for the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input bdq_pkg::word_t      rsp_value_res,
	input logic [1:0]          rsp_status,
	input logic                rsp_last
);
	import bdq_pkg::*;

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_res)
			&& $stable(rsp_status) && $stable(rsp_last))
		else $error("result changed while stalled");

	// any non-ok status is a single-transfer answer with a zero word
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_value_res == '0))
		else $error("status result without last or with nonzero word");

	// no new request is taken while a traverse still has words to send
	a_trav_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("request ready in the middle of a traverse");

endmodule

bind bounded_deque_with_positional_delete_unit bdq_chk u_bdq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_res (rsp.value_res),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);

FILE: tb/bounded_deque_with_positional_delete_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_delete_unit_test
// Drives appends, removals and traversals into the deque unit with random
// stalls on both channels. A scoreboard keeps its own copy of the stored words
// and checks every response transfer in order.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_delete_unit_test;
	import bdq_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 160;
	localparam int CALM_ITEMS = 40;
	localparam int PHASE_LEN = 40;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 2 * STORE_DEPTH;
	localparam logic [2:0] FN_SPARE_A = 3'd5;
	localparam logic [2:0] FN_SPARE_B = 3'd6;
	localparam logic [2:0] FN_SPARE_C = 3'd7;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		word_t   value_res;
		status_e status;
		logic    last;
	} rsp_item_t;

	class deque_scoreboard;
		word_t       words[STORE_DEPTH];
		int unsigned occupancy;
		rsp_item_t   due_rsp[$];
		int unsigned errors;
		int unsigned by_func[8];
		int unsigned by_status[4];
		int unsigned responses;

		function void push_status(status_e st);
			rsp_item_t r;
			r.value_res = '0;
			r.status = st;
			r.last = 1'b1;
			due_rsp.push_back(r);
		endfunction

		function void remove_slot(int unsigned idx);
			for (int unsigned j = idx; j + 1 < occupancy; j++)
				words[j] = words[j + 1];
			occupancy--;
		endfunction

		// accepted request: update the shadow store and queue what it should return
		function void apply_request(logic [2:0] fn, word_t val, logic [4:0] pos);
			rsp_item_t r;
			by_func[fn]++;
			case (fn)
				FN_APPEND: begin
					if (occupancy >= STORE_DEPTH) begin
						push_status(ST_FULL);
					end else begin
						words[occupancy] = val;
						occupancy++;
						push_status(ST_OK);
					end
				end
				FN_DEL_FIRST, FN_DEL_POS, FN_DEL_LAST: begin
					if (occupancy == 0) begin
						push_status(ST_EMPTY);
					end else if (fn == FN_DEL_FIRST) begin
						remove_slot(0);
						push_status(ST_OK);
					end else if (fn == FN_DEL_LAST) begin
						occupancy--;
						push_status(ST_OK);
					end else if (pos == 0 || pos > occupancy) begin
						push_status(ST_RANGE);
					end else begin
						remove_slot(pos - 1);
						push_status(ST_OK);
					end
				end
				FN_TRAVERSE: begin
					if (occupancy == 0) begin
						push_status(ST_EMPTY);
					end else begin
						for (int unsigned j = 0; j < occupancy; j++) begin
							r.value_res = words[j];
							r.status = ST_OK;
							r.last = (j + 1 == occupancy);
							due_rsp.push_back(r);
						end
					end
				end
				default: ;	// spare codes are dropped
			endcase
		endfunction

		function void check_response(word_t got_value, logic [1:0] got_status,
			logic got_last);
			rsp_item_t want;
			responses++;
			if (due_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected response: expected none, got %h %0d %0b",
					$time, got_value, got_status, got_last);
				return;
			end
			want = due_rsp.pop_front();
			by_status[want.status]++;
			if (got_value !== want.value_res) begin
				errors++;
				$display("%0t: value_res mismatch: expected %h, got %h",
					$time, want.value_res, got_value);
			end
			if (got_status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, got_status);
			end
			if (got_last !== want.last) begin
				errors++;
				$display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got_last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit no_idle = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	deque_scoreboard sb = new();

	bdq_req_if req_ch();
	bdq_rsp_if rsp_ch();

	bounded_deque_with_positional_delete_unit #(
		.DEPTH(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// response side: random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.value_res, rsp_ch.status, rsp_ch.last);
			if (req_ch.valid && req_ch.ready)
				sb.apply_request(req_ch.func, req_ch.value, req_ch.position);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d responses outstanding",
					$time, idle_cycles, sb.due_rsp.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_request(input logic [2:0] fn, input word_t val, input logic [4:0] pos);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.value <= val;
		req_ch.position <= pos;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned pick;
		bit filling;
		logic [2:0] fn;
		word_t val;
		logic [4:0] pos;

		req_ch.valid = 1'b0;
		req_ch.func = FN_APPEND;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty store, extremes, range errors, spare codes, last entry
		send_request(FN_TRAVERSE, '0, '0);
		send_request(FN_DEL_FIRST, '0, '0);
		send_request(FN_DEL_POS, '0, 5'd1);
		send_request(FN_DEL_LAST, '0, '0);
		send_request(FN_APPEND, WORD_MIN, '0);
		send_request(FN_APPEND, WORD_MAX, '1);
		send_request(FN_APPEND, '0, '0);
		send_request(FN_APPEND, -32'sd1, '0);
		send_request(FN_TRAVERSE, '0, '0);
		send_request(FN_DEL_POS, '0, 5'd0);
		send_request(FN_DEL_POS, '0, 5'd5);
		send_request(FN_DEL_POS, '1, 5'd31);
		send_request(FN_DEL_POS, '0, 5'd2);
		send_request(FN_DEL_LAST, '0, '0);
		send_request(FN_SPARE_A, 32'sh1234_5678, 5'd1);
		send_request(FN_SPARE_B, '0, '0);
		send_request(FN_SPARE_C, '1, '1);
		send_request(FN_TRAVERSE, '0, '0);
		send_request(FN_DEL_FIRST, '0, '0);
		send_request(FN_TRAVERSE, '0, '0);
		send_request(FN_DEL_POS, '0, 5'd1);	// only entry goes, store empty
		send_request(FN_TRAVERSE, '0, '0);

		// random: alternate fill and drain phases so the store swings full to empty
		filling = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_LEN == 0)
				filling = !filling;
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				no_idle = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				fn = 3'($urandom_range(FN_SPARE_A, FN_SPARE_C));
			else if (pick < (filling ? 73 : 23))
				fn = FN_APPEND;
			else if (pick < (filling ? 79 : 43))
				fn = FN_DEL_FIRST;
			else if (pick < (filling ? 85 : 68))
				fn = FN_DEL_POS;
			else if (pick < (filling ? 91 : 88))
				fn = FN_DEL_LAST;
			else
				fn = FN_TRAVERSE;
			pick = $urandom_range(0, 19);
			if (pick < 2)
				val = WORD_MIN;
			else if (pick < 4)
				val = WORD_MAX;
			else if (pick == 4)
				val = '0;
			else if (pick == 5)
				val = -32'sd1;
			else
				val = word_t'($urandom);
			if (sb.occupancy > 0 && $urandom_range(0, 3) != 0)
				pos = 5'($urandom_range(1, sb.occupancy));
			else
				pos = 5'($urandom_range(0, 31));
			send_request(fn, val, pos);
		end
		req_ch.valid <= 1'b0;

		while (sb.due_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Requests: %0d append, %0d remove first, %0d remove at, %0d remove last,",
			sb.by_func[FN_APPEND], sb.by_func[FN_DEL_FIRST], sb.by_func[FN_DEL_POS],
			sb.by_func[FN_DEL_LAST]);
		$display("  %0d traverse, %0d spare; responses: %0d checked (%0d ok, %0d empty,",
			sb.by_func[FN_TRAVERSE],
			sb.by_func[FN_SPARE_A] + sb.by_func[FN_SPARE_B] + sb.by_func[FN_SPARE_C],
			sb.responses, sb.by_status[ST_OK], sb.by_status[ST_EMPTY]);
		$display("  %0d full, %0d out of range)",
			sb.by_status[ST_FULL], sb.by_status[ST_RANGE]);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/bdq_pkg.sv
src/bdq_if.sv
src/bdq_cell.sv
src/bounded_deque_with_positional_delete_unit.sv
src/bdq_chk.sv
tb/bounded_deque_with_positional_delete_unit_test.sv
